/* sv/hlp_pkg.sv */
// shared types and constants for the hypergraph label propagation core
// no dependencies
package hlp_pkg;
   localparam int MaxNodes = 64;
   localparam int MaxEdges = 64;
   localparam int NodeIdxWidth = $clog2(MaxNodes);
   localparam int EdgeIdxWidth = $clog2(MaxEdges);
   localparam int LabelWidth = 4;
   localparam int NumLabels = 16;
   localparam int CountWidth = 7;
   localparam int RoundWidth = 17;

   localparam logic [2:0] CmdWriteHit  = 3'd0;
   localparam logic [2:0] CmdWriteNode = 3'd1;
   localparam logic [2:0] CmdRun       = 3'd2;
   localparam logic [2:0] CmdReadNode  = 3'd3;
   localparam logic [2:0] CmdReadEdge  = 3'd4;

   localparam logic [1:0] CsrNodeCount = 2'd0;
   localparam logic [1:0] CsrEdgeCount = 2'd1;
   localparam logic [1:0] CsrMaxRounds = 2'd2;

   typedef struct packed {
      logic [2:0] command;
      logic [5:0] node_index;
      logic [5:0] edge_index;
      logic [3:0] write_value;
   } req_type;

   typedef struct packed {
      logic [3:0]  label_out;
      logic [16:0] rounds_done;
      logic        converged;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                    wipe;         // clearing pass after reset
      logic                    clear_tally;  // start a new tally
      logic                    tally_en;     // count one member
      logic                    edge_phase;   // 1 when edges are being labeled
      logic [NodeIdxWidth-1:0] row;          // node index
      logic [EdgeIdxWidth-1:0] col;          // edge index
      logic                    commit;       // write the winner back
      logic                    clear_change;
   } ctl_type;

   typedef struct packed {
      logic changed;
   } sts_type;
endpackage

/* sv/hlp_datapath.sv */
// storage, tally and winner logic of the label propagation core
// depends on hlp_pkg
module hlp_datapath (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_hit,
   input  logic            wr_node,
   input  hlp_pkg::req_type req,
   input  hlp_pkg::ctl_type ctl,
   output hlp_pkg::sts_type sts,
   output logic [3:0]      node_rd,
   output logic [3:0]      edge_rd
);
   import hlp_pkg::*;

   logic [MaxEdges-1:0]   inc_mem [MaxNodes];
   logic [LabelWidth-1:0] node_mem [MaxNodes];
   logic [LabelWidth-1:0] edge_mem [MaxEdges];
   logic [CountWidth-1:0] cnt_ff [NumLabels];
   ctl_type               ctl_ff;
   logic [MaxEdges-1:0]   row_bits_ff;
   logic [LabelWidth-1:0] scan_node_ff, scan_edge_ff;
   logic [LabelWidth-1:0] node_rd_ff, edge_rd_ff;
   logic [CountWidth-1:0] best_ff, best_in;
   logic [LabelWidth-1:0] win_ff, win_in;
   logic                  chg_ff, chg_in;
   logic                  hit;
   logic [LabelWidth-1:0] lab, cur;
   logic [CountWidth-1:0] inc_cnt;

   // tally and commit act in the cycle after the controller issues them, on registered reads
   assign hit = row_bits_ff[ctl_ff.col];
   assign lab = ctl_ff.edge_phase ? scan_node_ff : scan_edge_ff;
   assign cur = ctl_ff.edge_phase ? scan_edge_ff : scan_node_ff;
   assign inc_cnt = cnt_ff[lab] + 1'b1;
   assign node_rd = node_rd_ff;
   assign edge_rd = edge_rd_ff;
   assign sts.changed = chg_ff;

   always_comb begin
      best_in = best_ff;
      win_in = win_ff;
      chg_in = chg_ff;
      if (ctl_ff.clear_tally) begin
         best_in = '0;
         win_in = '0;
      end else if (ctl_ff.tally_en && hit && lab != '0 && inc_cnt > best_ff) begin
         best_in = inc_cnt;
         win_in = lab;
      end
      if (ctl_ff.clear_change) chg_in = 1'b0;
      else if (ctl_ff.commit && cur != win_ff) chg_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         for (int k = 0; k < NumLabels; k++) cnt_ff[k] <= '0;
         best_ff <= '0;
         win_ff <= '0;
         chg_ff <= 1'b0;
      end else begin
         ctl_ff <= ctl;
         best_ff <= best_in;
         win_ff <= win_in;
         chg_ff <= chg_in;
         if (ctl_ff.clear_tally) begin
            for (int k = 0; k < NumLabels; k++) cnt_ff[k] <= '0;
         end else if (ctl_ff.tally_en && hit && lab != '0) begin
            cnt_ff[lab] <= inc_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wipe) inc_mem[ctl.row] <= '0;
      else if (wr_hit) inc_mem[req.node_index][req.edge_index] <= req.write_value[0];
      row_bits_ff <= inc_mem[ctl.row];
   end

   always_ff @(posedge clock) begin
      if (ctl.wipe) node_mem[ctl.row] <= '0;
      else if (ctl_ff.commit && !ctl_ff.edge_phase) node_mem[ctl_ff.row] <= win_ff;
      else if (wr_node) node_mem[req.node_index] <= req.write_value;
      scan_node_ff <= node_mem[ctl.row];
      node_rd_ff <= node_mem[req.node_index];
   end

   always_ff @(posedge clock) begin
      if (ctl.wipe) edge_mem[ctl.col] <= '0;
      else if (ctl_ff.commit && ctl_ff.edge_phase) edge_mem[ctl_ff.col] <= win_ff;
      scan_edge_ff <= edge_mem[ctl.col];
      edge_rd_ff <= edge_mem[req.edge_index];
   end
endmodule

/* sv/hlp_controller.sv */
// run sequencer of the label propagation core: walks rows and columns per round
// depends on hlp_pkg
module hlp_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        run,
   input  logic [hlp_pkg::CountWidth-1:0] node_count,
   input  logic [hlp_pkg::CountWidth-1:0] edge_count,
   input  logic [hlp_pkg::RoundWidth-1:0] max_rounds,
   input  hlp_pkg::sts_type            sts,
   output hlp_pkg::ctl_type            ctl,
   output logic                        busy,
   output logic                        done,
   output logic [hlp_pkg::RoundWidth-1:0] rounds,
   output logic                        conv
);
   import hlp_pkg::*;

   typedef enum logic [3:0] {
      StClear, StIdle, StCheck, StEdgeScan, StEdgeCommit, StEdgeDone,
      StNodeScan, StNodeCommit, StNodeDone, StEnd
   } state_type;

   state_type                state_ff;
   logic [NodeIdxWidth-1:0]  row_ff;
   logic [EdgeIdxWidth-1:0]  col_ff;
   logic [NodeIdxWidth-1:0]  nlast_ff;
   logic [EdgeIdxWidth-1:0]  elast_ff;
   logic [RoundWidth-1:0]    rounds_ff;
   logic                     conv_ff, done_ff;

   assign busy = state_ff != StIdle;
   assign done = done_ff;
   assign rounds = rounds_ff;
   assign conv = conv_ff;

   always_comb begin
      ctl = '0;
      ctl.row = row_ff;
      ctl.col = col_ff;
      case (state_ff)
         StClear: ctl.wipe = 1'b1;
         StEdgeScan: begin
            ctl.edge_phase = 1'b1;
            ctl.tally_en = 1'b1;
         end
         StEdgeCommit: begin
            ctl.edge_phase = 1'b1;
            ctl.commit = 1'b1;
            ctl.clear_tally = 1'b1;
         end
         StNodeScan: ctl.tally_en = 1'b1;
         StNodeCommit: begin
            ctl.commit = 1'b1;
            ctl.clear_tally = 1'b1;
         end
         StCheck: begin
            ctl.clear_tally = 1'b1;
            ctl.clear_change = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         row_ff <= '0;
         col_ff <= '0;
         nlast_ff <= '0;
         elast_ff <= '0;
         rounds_ff <= '0;
         conv_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            StClear: begin
               row_ff <= row_ff + 1'b1;
               col_ff <= col_ff + 1'b1;
               if (row_ff == NodeIdxWidth'(MaxNodes - 1)) state_ff <= StIdle;
            end
            StIdle: begin
               if (run) begin
                  nlast_ff <= (node_count == '0) ? '0 :
                     (node_count > CountWidth'(MaxNodes)) ? NodeIdxWidth'(MaxNodes - 1) :
                     NodeIdxWidth'(node_count - 1'b1);
                  elast_ff <= (edge_count == '0) ? '0 :
                     (edge_count > CountWidth'(MaxEdges)) ? EdgeIdxWidth'(MaxEdges - 1) :
                     EdgeIdxWidth'(edge_count - 1'b1);
                  rounds_ff <= '0;
                  conv_ff <= 1'b0;
                  state_ff <= StCheck;
               end
            end
            StCheck: begin
               row_ff <= '0;
               col_ff <= '0;
               if (rounds_ff < max_rounds) state_ff <= StEdgeScan;
               else state_ff <= StEnd;
            end
            StEdgeScan: begin
               if (row_ff == nlast_ff) begin
                  state_ff <= StEdgeCommit;
               end else row_ff <= row_ff + 1'b1;
            end
            StEdgeCommit: begin
               row_ff <= '0;
               if (col_ff == elast_ff) begin
                  col_ff <= '0;
                  state_ff <= StEdgeDone;
               end else begin
                  col_ff <= col_ff + 1'b1;
                  state_ff <= StEdgeScan;
               end
            end
            // let the last edge label land before the node phase reads it
            StEdgeDone: state_ff <= StNodeScan;
            StNodeScan: begin
               if (col_ff == elast_ff) state_ff <= StNodeCommit;
               else col_ff <= col_ff + 1'b1;
            end
            StNodeCommit: begin
               col_ff <= '0;
               if (row_ff == nlast_ff) begin
                  rounds_ff <= rounds_ff + 1'b1;
                  state_ff <= StNodeDone;
               end else begin
                  row_ff <= row_ff + 1'b1;
                  state_ff <= StNodeScan;
               end
            end
            // let the change flag settle after the last node commit
            StNodeDone: state_ff <= StEnd;
            StEnd: begin
               if (rounds_ff != '0 && !sts.changed && rounds_ff <= max_rounds
                   && state_ff == StEnd && row_ff == nlast_ff) begin
                  conv_ff <= 1'b1;
                  state_ff <= StIdle;
                  done_ff <= 1'b1;
               end else if (rounds_ff < max_rounds && rounds_ff != '0) begin
                  state_ff <= StCheck;
               end else begin
                  state_ff <= StIdle;
                  done_ff <= 1'b1;
               end
            end
            default: state_ff <= StIdle;
         endcase
      end
   end
endmodule

/* sv/hypergraph_label_propagation_core.sv */
// top level of the hypergraph label propagation core
// depends on hlp_pkg, hlp_controller, hlp_datapath
//
//  channel  handshake             payload
//  request  start / busy          req_data  (hlp_pkg::req_type)
//  response rsp_valid strobe      rsp_data  (hlp_pkg::rsp_type)
//  csr      csr_we, csr_index     csr_data  (17 bits)
//
// load and read commands: one per cycle while busy is low, response in the next cycle
// run: each round scans every edge over all nodes, then every node over all edges,
//   one member per cycle in the tally over the incidence matrix
// busy stays high for the whole run; response strobes when it ends
// after reset a clearing pass over all rows holds busy high; the receiver cannot stall
module hypergraph_label_propagation_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hlp_pkg::req_type req_data,
   output logic             rsp_valid,
   output hlp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [16:0]      csr_data
);
   import hlp_pkg::*;

   logic [CountWidth-1:0] ncount_ff, ecount_ff;
   logic [RoundWidth-1:0] maxr_ff;
   logic                  accept, run, wr_hit, wr_node, ctl_busy, run_done, conv;
   logic [RoundWidth-1:0] rounds;
   logic [3:0]            node_rd, edge_rd, label;
   logic                  quick_ff;
   logic [2:0]            cmd_ff;
   ctl_type               ctl;
   sts_type               sts;

   assign accept = start && !busy;
   assign run = accept && req_data.command == CmdRun;
   assign wr_hit = accept && req_data.command == CmdWriteHit;
   assign wr_node = accept && req_data.command == CmdWriteNode;
   assign busy = ctl_busy;

   always_comb begin
      case (cmd_ff)
         CmdReadNode: label = node_rd;
         CmdReadEdge: label = edge_rd;
         default:     label = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff <= CountWidth'(64);
         ecount_ff <= CountWidth'(64);
         maxr_ff <= RoundWidth'(99999);
         quick_ff <= 1'b0;
         cmd_ff <= '0;
      end else begin
         quick_ff <= accept && !run;
         if (accept) cmd_ff <= req_data.command;
         if (csr_we) begin
            case (csr_index)
               CsrNodeCount: ncount_ff <= csr_data[CountWidth-1:0];
               CsrEdgeCount: ecount_ff <= csr_data[CountWidth-1:0];
               CsrMaxRounds: maxr_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = quick_ff || run_done;
   assign rsp_data.label_out = quick_ff ? label : '0;
   assign rsp_data.rounds_done = rounds;
   assign rsp_data.converged = conv;

   hlp_controller u_ctrl (
      .clock(clock), .reset(reset), .run(run),
      .node_count(ncount_ff), .edge_count(ecount_ff), .max_rounds(maxr_ff),
      .sts(sts), .ctl(ctl), .busy(ctl_busy), .done(run_done),
      .rounds(rounds), .conv(conv)
   );

   hlp_datapath u_dp (
      .clock(clock), .reset(reset), .wr_hit(wr_hit), .wr_node(wr_node),
      .req(req_data), .ctl(ctl), .sts(sts), .node_rd(node_rd), .edge_rd(edge_rd)
   );
endmodule
